// ----- design/xbg_pkg.sv -----
// ---------------------------------------------------------------------------
// xbg_pkg
// Shared types and constants for the xoshiro256+ byte generator.
// ---------------------------------------------------------------------------
package xbg_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_REQUEST_BYTES_DEF = 256;
    localparam int WARMUP_STEPS_DEF      = 100;

    // Request never yields more than 33 results
    localparam int HARD_BYTE_CAP = 263;

    // Field widths
    localparam int WORD_W   = 64;
    localparam int COUNT_W  = 9;
    localparam int VBYTES_W = 4;
    localparam int CHUNK_W  = 6;
    localparam int REST_W   = 3;
    localparam int WARM_W   = 7;
    localparam int ADDR_W   = 3;

    // Register map
    localparam logic [ADDR_W-1:0] ADDR_SEED_VALUE = 3'd0;

    // Byte counts of an output word
    localparam logic [VBYTES_W-1:0] VBYTES_NONE = 4'd0;
    localparam logic [VBYTES_W-1:0] VBYTES_FULL = 4'd8;

    // Controller to datapath commands
    typedef struct packed {
        logic                seed;    // load seed into word 0, clear the rest
        logic                step;    // advance the generator one step
        logic                load;    // capture a result in the output register
        logic [VBYTES_W-1:0] vbytes;  // valid low-order bytes of that result
        logic                last;    // final result of the transaction
    } xbg_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;               // output register can take a result
    } xbg_status_t;

endpackage

// ----- design/xbg_ctrl.sv -----
// ---------------------------------------------------------------------------
// xbg_ctrl
// Request sequencer: seeding, warm-up and word emission control.
// ---------------------------------------------------------------------------
module xbg_ctrl #(
    parameter int MaxRequestBytes = xbg_pkg::MAX_REQUEST_BYTES_DEF,
    parameter int WarmupSteps     = xbg_pkg::WARMUP_STEPS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic [xbg_pkg::COUNT_W-1:0]  byte_count,
    input  logic                         secure_only,
    input  xbg_pkg::xbg_status_t         status,
    output xbg_pkg::xbg_cmd_t            cmd
);

    localparam int CapBytes = (MaxRequestBytes < xbg_pkg::HARD_BYTE_CAP) ?
                              MaxRequestBytes : xbg_pkg::HARD_BYTE_CAP;
    localparam logic [xbg_pkg::COUNT_W-1:0] CapCount = xbg_pkg::COUNT_W'(CapBytes);
    localparam logic [xbg_pkg::WARM_W-1:0]  WarmLast =
        xbg_pkg::WARM_W'((WarmupSteps > 0) ? (WarmupSteps - 1) : 0);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMPTY,
        ST_SEED,
        ST_WARM,
        ST_EMIT
    } state_t;

    state_t                        state_reg, state_next;
    logic                          seeded_reg, seeded_next;
    logic [xbg_pkg::WARM_W-1:0]    warm_cnt_reg, warm_cnt_next;
    logic [xbg_pkg::REST_W-1:0]    rest_reg, rest_next;
    logic [xbg_pkg::CHUNK_W-1:0]   chunks_reg, chunks_next;
    logic [xbg_pkg::COUNT_W-1:0]   eff_count;
    logic                          accept;
    logic                          rest_pend;
    logic                          last_now;

    // Saturate the requested count
    assign eff_count = (byte_count > CapCount) ? CapCount : byte_count;
    assign accept    = req_valid && (state_reg == ST_IDLE);
    assign req_stall = (state_reg != ST_IDLE);

    // Partial word goes first, last flag on the final word
    assign rest_pend = (rest_reg != '0);
    assign last_now  = rest_pend ? (chunks_reg == '0)
                                 : (chunks_reg == xbg_pkg::CHUNK_W'(1));

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        seeded_next   = seeded_reg;
        warm_cnt_next = warm_cnt_reg;
        rest_next     = rest_reg;
        chunks_next   = chunks_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rest_next   = eff_count[xbg_pkg::REST_W-1:0];
                    chunks_next = eff_count[xbg_pkg::COUNT_W-1:xbg_pkg::REST_W];
                    if (secure_only || (eff_count == '0))
                        state_next = ST_EMPTY;
                    else if (!seeded_reg)
                        state_next = ST_SEED;
                    else
                        state_next = ST_EMIT;
                end
            end
            ST_EMPTY:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.vbytes = xbg_pkg::VBYTES_NONE;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SEED:
            begin
                cmd.seed      = 1'b1;
                seeded_next   = 1'b1;
                warm_cnt_next = '0;
                state_next    = (WarmupSteps > 0) ? ST_WARM : ST_EMIT;
            end
            ST_WARM:
            begin
                cmd.step      = 1'b1;
                warm_cnt_next = warm_cnt_reg + 1'b1;
                if (warm_cnt_reg == WarmLast)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.step   = 1'b1;
                    cmd.load   = 1'b1;
                    cmd.last   = last_now;
                    if (rest_pend)
                    begin
                        cmd.vbytes = {1'b0, rest_reg};
                        rest_next  = '0;
                    end
                    else
                    begin
                        cmd.vbytes  = xbg_pkg::VBYTES_FULL;
                        chunks_next = chunks_reg - 1'b1;
                    end
                    if (last_now)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            seeded_reg   <= 1'b0;
            warm_cnt_reg <= '0;
            rest_reg     <= '0;
            chunks_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            seeded_reg   <= seeded_next;
            warm_cnt_reg <= warm_cnt_next;
            rest_reg     <= rest_next;
            chunks_reg   <= chunks_next;
        end
    end

endmodule

// ----- design/xbg_datapath.sv -----
// ---------------------------------------------------------------------------
// xbg_datapath
// Generator state words, xoshiro256+ step and output register.
// ---------------------------------------------------------------------------
module xbg_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  xbg_pkg::xbg_cmd_t             cmd,
    output xbg_pkg::xbg_status_t          status,
    input  logic [xbg_pkg::WORD_W-1:0]    seed_value,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [xbg_pkg::WORD_W-1:0]    random_word,
    output logic [xbg_pkg::VBYTES_W-1:0]  valid_bytes,
    output logic                          last_word
);

    localparam int W = xbg_pkg::WORD_W;

    logic [W-1:0]                  s0_reg, s1_reg, s2_reg, s3_reg;
    logic [W-1:0]                  s0_next, s1_next, s2_next, s3_next;
    logic [W-1:0]                  x2, x3, x1, x0, t;
    logic [W-1:0]                  sum;
    logic [W-1:0]                  masked;
    logic                          rsp_valid_reg;
    logic [W-1:0]                  word_reg;
    logic [xbg_pkg::VBYTES_W-1:0]  vbytes_reg;
    logic                          last_reg;

    // Output of the step and the xor/shift/rotate update
    assign sum = s0_reg + s3_reg;
    assign t   = s1_reg << 17;
    assign x2  = s2_reg ^ s0_reg;
    assign x3  = s3_reg ^ s1_reg;
    assign x1  = s1_reg ^ x2;
    assign x0  = s0_reg ^ x3;

    // Keep only the valid low-order bytes
    always_comb
    begin
        for (int i = 0; i < 8; i++)
            masked[8*i +: 8] = (xbg_pkg::VBYTES_W'(i) < cmd.vbytes) ? sum[8*i +: 8] : 8'h00;
    end

    // Next generator state
    always_comb
    begin
        s0_next = s0_reg;
        s1_next = s1_reg;
        s2_next = s2_reg;
        s3_next = s3_reg;
        priority if (cmd.seed)
        begin
            s0_next = seed_value;
            s1_next = '0;
            s2_next = '0;
            s3_next = '0;
        end
        else if (cmd.step)
        begin
            s0_next = x0;
            s1_next = x1;
            s2_next = x2 ^ t;
            s3_next = {x3[W-46:0], x3[W-1:W-45]};
        end
    end

    // Generator words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
        end
        else
        begin
            s0_reg <= s0_next;
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

    // Output register
    assign status.out_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.load)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg   <= masked;
            vbytes_reg <= cmd.vbytes;
            last_reg   <= cmd.last;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign random_word = word_reg;
    assign valid_bytes = vbytes_reg;
    assign last_word   = last_reg;

endmodule

// ----- design/xoshiro256_plus_byte_generator_unit.sv -----
// ---------------------------------------------------------------------------
// xoshiro256_plus_byte_generator_unit
// Xoshiro256+ generator answering requests for random bytes.
// ---------------------------------------------------------------------------
// Request channel (req_valid/req_stall): byte_count and secure_only. One
// request is taken at a time; req_stall is high from acceptance until the
// last result of the transaction has been loaded into the output register.
// Response channel (rsp_valid/rsp_stall): random_word, valid_bytes and
// last_word. A request of N bytes, N capped at the smaller of MaxRequestBytes
// and 263, gives a partial word of N mod 8 bytes, if nonzero, then N/8 full
// words; secure_only or N = 0 gives one empty word. After acceptance the
// controller loads one word per cycle into the output register while the
// receiver does not stall, one generator step each. The first request that
// steps the generator after reset adds a seeding step and WarmupSteps
// warm-up steps. Reset clears the generator words, the seed register and the
// seeded flag. While the receiver stalls, the output register holds its word
// and the generator takes no emission step. The seed register is written
// over the APB port at byte address 0 and read back on prdata.
// ---------------------------------------------------------------------------
module xoshiro256_plus_byte_generator_unit #(
    parameter int MaxRequestBytes = xbg_pkg::MAX_REQUEST_BYTES_DEF,
    parameter int WarmupSteps     = xbg_pkg::WARMUP_STEPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [xbg_pkg::ADDR_W-1:0]    paddr,
    input  logic [xbg_pkg::WORD_W-1:0]    pwdata,
    output logic [xbg_pkg::WORD_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [xbg_pkg::COUNT_W-1:0]   byte_count,
    input  logic                          secure_only,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [xbg_pkg::WORD_W-1:0]    random_word,
    output logic [xbg_pkg::VBYTES_W-1:0]  valid_bytes,
    output logic                          last_word
);

    logic [xbg_pkg::WORD_W-1:0] seed_value_reg;
    xbg_pkg::xbg_cmd_t          cmd;
    xbg_pkg::xbg_status_t       status;

    // Seed register
    assign pready = 1'b1;
    assign prdata = (paddr == xbg_pkg::ADDR_SEED_VALUE) ? seed_value_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_value_reg <= '0;
        else if (psel && penable && pwrite && (paddr == xbg_pkg::ADDR_SEED_VALUE))
            seed_value_reg <= pwdata;
    end

    xbg_ctrl #(
        .MaxRequestBytes (MaxRequestBytes),
        .WarmupSteps     (WarmupSteps)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .byte_count  (byte_count),
        .secure_only (secure_only),
        .status      (status),
        .cmd         (cmd)
    );

    xbg_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .seed_value  (seed_value_reg),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .random_word (random_word),
        .valid_bytes (valid_bytes),
        .last_word   (last_word)
    );

endmodule

// ----- design/xbg_checker.sv -----
// ---------------------------------------------------------------------------
// xbg_checker
// Port-level checks for the xoshiro256+ byte generator.
// ---------------------------------------------------------------------------
module xbg_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_stall,
    input logic                          rsp_valid,
    input logic                          rsp_stall,
    input logic [xbg_pkg::WORD_W-1:0]    random_word,
    input logic [xbg_pkg::VBYTES_W-1:0]  valid_bytes,
    input logic                          last_word
);

    // Stalled response holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(random_word)
            && $stable(valid_bytes) && $stable(last_word))
        else $error("response changed while stalled");

    // Never more than a full word of bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> valid_bytes <= xbg_pkg::VBYTES_FULL)
        else $error("valid_bytes above eight");

    // Empty result is zero and closes the transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (valid_bytes == xbg_pkg::VBYTES_NONE)
            |-> last_word && (random_word == '0))
        else $error("empty result not zero or not marked last");

    // One request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while busy");

endmodule

bind xoshiro256_plus_byte_generator_unit xbg_checker u_xbg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .random_word (random_word),
    .valid_bytes (valid_bytes),
    .last_word   (last_word)
);
